/* hdl/clxm_pkg.sv */
package clxm_pkg;

  localparam logic [63:0] SEED_V_INIT = 64'd4101842887655102017;
  localparam logic [63:0] LCG_MUL     = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD     = 64'd7046029254386353087;
  localparam logic [31:0] MWC_MUL     = 32'd4294957665;

  localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
  localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

  // multiplier step codes
  localparam logic [1:0] STEP_LCG_LL = 2'd0;
  localparam logic [1:0] STEP_LCG_HL = 2'd1;
  localparam logic [1:0] STEP_LCG_LH = 2'd2;
  localparam logic [1:0] STEP_MWC    = 2'd3;

  // advance phases: three seeding advances, then the generating one
  localparam logic [1:0] PH_SEED0 = 2'd0;
  localparam logic [1:0] PH_SEED1 = 2'd1;
  localparam logic [1:0] PH_SEED2 = 2'd2;
  localparam logic [1:0] PH_GEN   = 2'd3;

  typedef struct packed {
    logic       load_seed;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       apply;
    logic       copy_vu;
    logic       copy_wv;
    logic       out_load;
  } cmd_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    logic [63:0] a;
    logic [63:0] b;
    a = v ^ (v >> 17);
    b = a ^ (a << 31);
    return b ^ (b >> 8);
  endfunction

  function automatic logic [63:0] temper(input logic [63:0] u);
    logic [63:0] a;
    logic [63:0] b;
    a = u ^ (u << 21);
    b = a ^ (a >> 35);
    return b ^ (b << 4);
  endfunction

endpackage

/* hdl/clxm_datapath.sv */
module clxm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  clxm_pkg::cmd_t    cmd,
  input  logic              cfg_we,
  input  logic [63:0]       cfg_seed,
  output logic [63:0]       value
);

  logic [63:0] seed;
  logic [63:0] u;
  logic [63:0] v;
  logic [63:0] w;
  logic [63:0] prod;
  logic [63:0] lcg_acc;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] v_next;
  logic [63:0] w_next;

  always_comb begin
    case (cmd.mul_step)
      clxm_pkg::STEP_LCG_LL: begin
        mul_a = u[31:0];
        mul_b = clxm_pkg::LCG_MUL_LO;
      end
      clxm_pkg::STEP_LCG_HL: begin
        mul_a = u[63:32];
        mul_b = clxm_pkg::LCG_MUL_LO;
      end
      clxm_pkg::STEP_LCG_LH: begin
        mul_a = u[31:0];
        mul_b = clxm_pkg::LCG_MUL_HI;
      end
      default: begin
        mul_a = w[31:0];
        mul_b = clxm_pkg::MWC_MUL;
      end
    endcase
  end

  // at apply time prod holds the MWC product
  assign v_next = clxm_pkg::xorshift(v);
  assign w_next = prod + {32'd0, w[63:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (cfg_we) begin
      seed <= cfg_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {32'd0, mul_a} * {32'd0, mul_b};
      case (cmd.mul_step)
        clxm_pkg::STEP_LCG_HL: lcg_acc <= prod + clxm_pkg::LCG_ADD;
        clxm_pkg::STEP_LCG_LH, clxm_pkg::STEP_MWC: begin
          lcg_acc[63:32] <= lcg_acc[63:32] + prod[31:0];
        end
        default: lcg_acc <= lcg_acc;
      endcase
    end
    if (cmd.load_seed) begin
      u <= seed ^ clxm_pkg::SEED_V_INIT;
      v <= clxm_pkg::SEED_V_INIT;
      w <= 64'd1;
    end else if (cmd.apply) begin
      u <= lcg_acc;
      v <= cmd.copy_vu ? lcg_acc : v_next;
      w <= cmd.copy_wv ? v_next : w_next;
    end
    if (cmd.out_load) begin
      value <= (clxm_pkg::temper(u) + v) ^ w;
    end
  end

endmodule

/* hdl/clxm_ctrl.sv */
module clxm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              reseed,
  output logic              out_valid,
  input  logic              out_stall,
  output clxm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_APPLY,
    ST_FIN
  } state_t;

  state_t      state;
  logic [1:0]  step;
  logic [1:0]  phase;
  logic        boot;
  logic        in_acc;
  logic        out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.load_seed = (state == ST_LOAD);
    cmd.mul_en    = (state == ST_MUL);
    cmd.mul_step  = step;
    cmd.apply     = (state == ST_APPLY);
    cmd.copy_vu   = (state == ST_APPLY) && (phase == clxm_pkg::PH_SEED0);
    cmd.copy_wv   = (state == ST_APPLY) && (phase == clxm_pkg::PH_SEED1);
    cmd.out_load  = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      step      <= clxm_pkg::STEP_LCG_LL;
      phase     <= clxm_pkg::PH_SEED0;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            step <= clxm_pkg::STEP_LCG_LL;
            if (reseed) begin
              state <= ST_LOAD;
              phase <= clxm_pkg::PH_SEED0;
            end else begin
              state <= ST_MUL;
              phase <= clxm_pkg::PH_GEN;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_MUL;
          step  <= clxm_pkg::STEP_LCG_LL;
        end
        ST_MUL: begin
          step <= step + 2'd1;
          if (step == clxm_pkg::STEP_MWC) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          step <= clxm_pkg::STEP_LCG_LL;
          if (phase == clxm_pkg::PH_GEN) begin
            state <= ST_FIN;
          end else if (phase == clxm_pkg::PH_SEED2 && boot) begin
            // power-up seeding returns no word
            state <= ST_IDLE;
            boot  <= 1'b0;
          end else begin
            state <= ST_MUL;
            phase <= phase + 2'd1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_apply_after_mwc: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |-> $past(state) == ST_MUL && $past(step) == clxm_pkg::STEP_MWC)
    else $error("apply without a full multiply sequence");

  a_fin_gen_only: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> phase == clxm_pkg::PH_GEN && !boot)
    else $error("result word from a seeding advance");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_LOAD || state == ST_MUL)
    else $error("accepted word did not start an advance");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !cmd.out_load |=> !out_valid)
    else $error("delivered word still shown");

endmodule

/* hdl/combined_lcg_xorshift_mwc_rng.sv */
// A plain request runs one advance and the output stage; a reseed request runs
// seed load, four advances and the output stage.
// A new request is not taken until the last word is loaded into value; each
// advance is paced by the single shared 32x32 multiplier (four products).
// Reset: seed clears to 0 and the state is seeded from it, with the input
// stalled until that is done.
module combined_lcg_xorshift_mwc_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        reseed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed
);

  clxm_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  clxm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reseed    (reseed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  clxm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_seed (seed),
    .value    (value)
  );

endmodule

/* test/tb_combined_lcg_xorshift_mwc_rng.sv */
module tb_combined_lcg_xorshift_mwc_rng;

  localparam logic [63:0] V_SEED_INIT = 64'd4101842887655102017;
  localparam logic [63:0] LCG_MULT    = 64'd2862933555777941757;
  localparam logic [63:0] LCG_INC     = 64'd7046029254386353087;
  localparam logic [63:0] MWC_MULT    = 64'd4294957665;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          HANG_LIMIT   = 4000;
  localparam int          RAND_PHASES  = 10;
  localparam int          PHASE_WORDS  = 85;

  // Tracks the generator state and the words still owed by the block.
  class rng_word_tracker;
    logic [63:0] seed_reg;
    logic [63:0] lcg_u;
    logic [63:0] xs_v;
    logic [63:0] mwc_w;
    logic [63:0] owed_words[$];
    int          errors;

    function new();
      errors   = 0;
      seed_reg = '0;
      reseed_state(seed_reg);
    endfunction

    function logic [63:0] next_rng_word();
      logic [63:0] t;
      lcg_u = lcg_u * LCG_MULT + LCG_INC;
      xs_v  = xs_v ^ (xs_v >> 17);
      xs_v  = xs_v ^ (xs_v << 31);
      xs_v  = xs_v ^ (xs_v >> 8);
      mwc_w = MWC_MULT * {32'd0, mwc_w[31:0]} + {32'd0, mwc_w[63:32]};
      t = lcg_u ^ (lcg_u << 21);
      t = t ^ (t >> 35);
      t = t ^ (t << 4);
      return (t + xs_v) ^ mwc_w;
    endfunction

    function void reseed_state(logic [63:0] s);
      logic [63:0] dummy;
      xs_v  = V_SEED_INIT;
      mwc_w = 64'd1;
      lcg_u = s ^ xs_v;
      dummy = next_rng_word();
      xs_v  = lcg_u;
      dummy = next_rng_word();
      mwc_w = xs_v;
      dummy = next_rng_word();
    endfunction

    function void set_seed(logic [63:0] s);
      seed_reg = s;
    endfunction

    function void note_request(logic rs);
      logic [63:0] nxt;
      if (rs)
        reseed_state(seed_reg);
      nxt = next_rng_word();
      owed_words = {owed_words, nxt};
    endfunction

    function void check_word(logic [63:0] got);
      logic [63:0] exp;
      if (owed_words.size() == 0) begin
        $error("value: no word expected, got %h", got);
        errors++;
      end else begin
        exp = owed_words.pop_front();
        if (got !== exp) begin
          $error("value: expected %h, actual %h", exp, got);
          errors++;
        end
      end
    endfunction

    function int owed();
      return owed_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        reseed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] seed = '0;

  rng_word_tracker tracker;
  bit              calm = 1'b0;
  int              stall_run = 0;
  int              hang_cycles = 0;

  combined_lcg_xorshift_mwc_rng u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reseed    (reseed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_run = pick_gap();
    end
  end

  // handshakes are settled by the falling edge; sample there
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_word(value);
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      hang_cycles = 0;
    else
      hang_cycles++;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // entered and left just after a rising edge
  task automatic send_word(input logic rs);
    int  gap;
    bit  taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      reseed   <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    reseed   <= rs;
    do begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      if (taken)
        tracker.note_request(rs);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_seed(input logic [63:0] s);
    bit taken;
    cfg_valid <= 1'b1;
    seed      <= s;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      if (taken)
        tracker.set_seed(s);
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.owed() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] s;
    int          pick;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // state seeded from zero at reset, then an explicit reseed must repeat it
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    drain();
    // a seed write alone leaves the running state alone
    write_seed('1);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    drain();
    // last of two writes wins
    write_seed(64'd1);
    write_seed(64'h8000_0000_0000_0000);
    send_word(1'b1);
    send_word(1'b0);
    drain();
    write_seed(64'hAAAA_AAAA_5555_5555);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph % 4 == 3);
      pick = $urandom_range(0, 5);
      case (pick)
        0: begin
          s = '0;
        end
        1: begin
          s = '1;
        end
        2: begin
          s = 64'd1 << $urandom_range(0, 63);
        end
        default: begin
          s = {$urandom, $urandom};
        end
      endcase
      write_seed(s);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word((i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0));
      drain();
    end

    if (tracker.errors == 0 && tracker.owed() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
